### rtl/core/rmrdr_pkg.sv
// Shared constants, CORDIC angle table and types for the matrix to RA/Dec/roll pipeline.
package rmrdr_pkg;

  // Input fields: signed matrix entries
  localparam int IN_W = 18;
  // Internal fixed point: Q30 angles and CORDIC vectors
  localparam int QB = 30;
  localparam int ANG30_W = 34;
  localparam int XY_W = 33;
  // Integer square root of a value up to 2^60
  localparam int SQ_W = 62;
  localparam int SQRT_ITERS = 31;
  localparam int ROOT_W = 31;

  localparam logic signed [ANG30_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [ANG30_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG30_W-1:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [ANG30_W-1:0] THREE_HALF_PI_Q30 = TWO_PI_Q30 - HALF_PI_Q30;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;

  // Image-up column, carried along the pipeline
  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } up_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ANG30_W-1:0] atan_q30(input int i);
    logic signed [ANG30_W-1:0] v;
    case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd7;
      28: v = 34'sd3;
      29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/rmrdr_in_if.sv
// Input channel: one beat carries the up and pointing columns of the rotation matrix.
interface rmrdr_in_if;
  import rmrdr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] up_x;
  logic signed [IN_W-1:0] up_y;
  logic signed [IN_W-1:0] up_z;
  logic signed [IN_W-1:0] point_x;
  logic signed [IN_W-1:0] point_y;
  logic signed [IN_W-1:0] point_z;

  modport source (
    output valid, up_x, up_y, up_z, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, up_x, up_y, up_z, point_x, point_y, point_z,
    output ready
  );
endinterface

### rtl/core/rmrdr_out_if.sv
// Output channel: one beat carries right ascension, declination and roll.
interface rmrdr_out_if #(
  parameter int FRAC_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic        [FRAC_BITS+2:0] right_ascension;
  logic signed [FRAC_BITS+1:0] declination;
  logic signed [FRAC_BITS+2:0] roll_angle;

  modport source (
    output valid, right_ascension, declination, roll_angle,
    input  ready
  );
  modport sink (
    input  valid, right_ascension, declination, roll_angle,
    output ready
  );
endinterface

### rtl/core/rmrdr_atan2.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q30, one iteration per stage.
module rmrdr_atan2 #(
  parameter int W     = 34,
  parameter int STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [W-1:0]                  y_in,
  input  logic signed [W-1:0]                  x_in,
  output logic signed [rmrdr_pkg::ANG30_W-1:0] z_out
);
  import rmrdr_pkg::*;

  logic signed [W-1:0]       xs [STEPS];
  logic signed [W-1:0]       ys [STEPS];
  logic signed [ANG30_W-1:0] zs [STEPS+1];
  logic                      zero_q [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      // Pre-rotation into the right half plane
      zero_q[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= HALF_PI_Q30;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -HALF_PI_Q30;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
      // Micro-rotations, one per stage
      for (int i = 0; i < STEPS - 1; i++) begin
        zero_q[i+1] <= zero_q[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(i);
        end
      end
      // Last stage only needs the angle
      zero_q[STEPS] <= zero_q[STEPS-1];
      if (ys[STEPS-1] > 0) begin
        zs[STEPS] <= zs[STEPS-1] + atan_q30(STEPS - 1);
      end else begin
        zs[STEPS] <= zs[STEPS-1] - atan_q30(STEPS - 1);
      end
    end
  end

  // atan2(0,0) is defined as zero
  assign z_out = zero_q[STEPS] ? '0 : zs[STEPS];

endmodule

### rtl/core/rmrdr_sincos.sv
// Pipelined rotation CORDIC: cosine and sine in Q30 of an angle with FRAC_BITS fraction bits.
module rmrdr_sincos #(
  parameter int FRAC_BITS = 16,
  parameter int STEPS     = 16,
  parameter int A_W       = 20
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [A_W-1:0]             ang,
  output logic signed [rmrdr_pkg::XY_W-1:0] cos_out,
  output logic signed [rmrdr_pkg::XY_W-1:0] sin_out
);
  import rmrdr_pkg::*;

  localparam int SH = QB - FRAC_BITS;

  logic signed [ANG30_W-1:0] a_in;
  logic signed [ANG30_W-1:0] as [STEPS];
  logic signed [XY_W-1:0]    xs [STEPS+1];
  logic signed [XY_W-1:0]    ys [STEPS+1];
  logic                      neg [STEPS+1];

  assign a_in = ANG30_W'(ang) <<< SH;

  always_ff @(posedge clk) begin
    if (en) begin
      // Fold the angle into [-pi/2, pi/2], remembering a sign flip
      xs[0] <= GAIN_Q30;
      ys[0] <= '0;
      if (a_in > PI_Q30) begin
        if (a_in < THREE_HALF_PI_Q30) begin
          as[0]  <= a_in - PI_Q30;
          neg[0] <= 1'b1;
        end else begin
          as[0]  <= a_in - TWO_PI_Q30;
          neg[0] <= 1'b0;
        end
      end else if (a_in > HALF_PI_Q30) begin
        as[0]  <= a_in - PI_Q30;
        neg[0] <= 1'b1;
      end else if (a_in < -HALF_PI_Q30) begin
        as[0]  <= a_in + PI_Q30;
        neg[0] <= 1'b1;
      end else begin
        as[0]  <= a_in;
        neg[0] <= 1'b0;
      end
      // Micro-rotations
      for (int i = 0; i < STEPS; i++) begin
        neg[i+1] <= neg[i];
        if (as[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
        end
      end
      for (int i = 0; i < STEPS - 1; i++) begin
        if (as[i] >= 0) begin
          as[i+1] <= as[i] - atan_q30(i);
        end else begin
          as[i+1] <= as[i] + atan_q30(i);
        end
      end
      // Undo the fold
      cos_out <= neg[STEPS] ? -xs[STEPS] : xs[STEPS];
      sin_out <= neg[STEPS] ? -ys[STEPS] : ys[STEPS];
    end
  end

endmodule

### rtl/core/rotation_matrix_to_radec_roll.sv
// Top level: rotation matrix columns to right ascension, declination and roll.
//
// Takes the image-up and pointing columns of a camera-to-celestial rotation
// matrix and returns right ascension in [0, 2pi), declination in [-pi/2, pi/2]
// and roll in [-pi, pi], all in radians with FRAC_BITS fraction bits. The block
// is a single pipeline that accepts one matrix every cycle unless a result beat
// is held at the output. Its depth is set by the chain of a 31-stage square
// root, the declination CORDIC, the sine/cosine CORDICs, the dot products and
// the roll CORDIC, each CORDIC taking one iteration per stage. When a result
// beat is held at the output the whole pipeline freezes, so nothing is dropped
// or repeated.
module rotation_matrix_to_radec_roll #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  rmrdr_in_if.sink     matrix,
  rmrdr_out_if.source  angles
);
  import rmrdr_pkg::*;

  localparam int N       = CORDIC_STEPS;
  localparam int SH      = QB - FRAC_BITS;
  localparam int RA_W    = FRAC_BITS + 3;
  localparam int DEC_W   = FRAC_BITS + 2;
  localparam int ROLL_W  = FRAC_BITS + 3;
  localparam int A_W     = FRAC_BITS + 4;
  localparam int Z30_W   = 32;
  localparam int PS_W    = IN_W + SH;
  localparam int RA_CW   = PS_W + 3;
  localparam int PR_W    = IN_W + XY_W;
  localparam int SUM_W   = PR_W + 2;
  localparam int ROLL_CW = SUM_W + 3;
  localparam int MP_W    = 2 * XY_W;
  localparam int LAT     = 2 * N + 59;
  localparam int D_Z     = 32;
  localparam int D_RA    = 32;
  localparam int D_U     = N + 54;
  localparam int D_OUT   = 2 * N + 7;

  localparam logic signed [Z30_W-1:0]   ONE_F      = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ANG30_W-1:0] ROUND_HALF = (ANG30_W'(1) << SH) >>> 1;
  localparam logic signed [ANG30_W-1:0] PI_F       = (PI_Q30 + ROUND_HALF) >>> SH;
  localparam logic signed [ANG30_W-1:0] HALF_PI_F  = (HALF_PI_Q30 + ROUND_HALF) >>> SH;
  localparam logic signed [ANG30_W-1:0] TWO_PI_F   = (TWO_PI_Q30 + ROUND_HALF) >>> SH;
  localparam logic signed [MP_W-1:0]    MP_RND     = MP_W'(1) << (QB - 1);
  localparam logic [SQ_W-1:0]           SQ_ONE     = SQ_W'(1) << (2 * QB);

  typedef struct packed {
    logic signed [A_W-1:0] ra;
    logic signed [A_W-1:0] dec;
  } angle_pair_t;

  // Q30 to output scale, round half up
  function automatic logic signed [ANG30_W-1:0] to_out(input logic signed [ANG30_W-1:0] v);
    return (v + ROUND_HALF) >>> SH;
  endfunction

  function automatic logic signed [ANG30_W-1:0] sat(input logic signed [ANG30_W-1:0] v,
                                                     input logic signed [ANG30_W-1:0] lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  logic en;
  logic [LAT-1:0] vld;

  // Pipeline advances unless the output beat is held
  assign en           = !vld[LAT-1] || angles.ready;
  assign matrix.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], matrix.valid};
    end
  end

  // Input stage: clamp z, scale to Q30
  logic signed [Z30_W-1:0] pz_w, pz_cl;
  logic signed [Z30_W-1:0] z30_s1;
  logic signed [PS_W-1:0]  px_s1, py_s1;
  up_t                     u_s1;

  assign pz_w  = Z30_W'(matrix.point_z);
  assign pz_cl = (pz_w > ONE_F) ? ONE_F : ((pz_w < -ONE_F) ? -ONE_F : pz_w);

  always_ff @(posedge clk) begin
    if (en) begin
      z30_s1 <= pz_cl <<< SH;
      px_s1  <= PS_W'(matrix.point_x) <<< SH;
      py_s1  <= PS_W'(matrix.point_y) <<< SH;
      u_s1   <= '{x: matrix.up_x, y: matrix.up_y, z: matrix.up_z};
    end
  end

  // z squared
  logic signed [2*Z30_W-1:0] sq_full;
  logic [SQ_W-1:0]           sq_s2;
  assign sq_full = z30_s1 * z30_s1;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s2 <= sq_full[SQ_W-1:0];
    end
  end

  // Floor square root of 2^60 - z^2, one result bit per stage
  logic [SQ_W-1:0]   v0;
  logic [SQ_W-1:0]   sqv [SQRT_ITERS-1];
  logic [SQ_W-1:0]   sqr [SQRT_ITERS-1];
  logic [SQ_W-1:0]   last_trial;
  logic [ROOT_W-1:0] c30;

  assign v0         = SQ_ONE - sq_s2;
  assign last_trial = sqr[SQRT_ITERS-2] + SQ_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (v0 >= SQ_ONE) begin
        sqv[0] <= v0 - SQ_ONE;
        sqr[0] <= SQ_ONE;
      end else begin
        sqv[0] <= v0;
        sqr[0] <= '0;
      end
      for (int j = 1; j < SQRT_ITERS - 1; j++) begin
        if (sqv[j-1] >= sqr[j-1] + (SQ_W'(1) << (2 * QB - 2 * j))) begin
          sqv[j] <= sqv[j-1] - (sqr[j-1] + (SQ_W'(1) << (2 * QB - 2 * j)));
          sqr[j] <= (sqr[j-1] >> 1) + (SQ_W'(1) << (2 * QB - 2 * j));
        end else begin
          sqv[j] <= sqv[j-1];
          sqr[j] <= sqr[j-1] >> 1;
        end
      end
      if (sqv[SQRT_ITERS-2] >= last_trial) begin
        c30 <= ROOT_W'((sqr[SQRT_ITERS-2] >> 1) + SQ_W'(1));
      end else begin
        c30 <= ROOT_W'(sqr[SQRT_ITERS-2] >> 1);
      end
    end
  end

  // Delay lines that keep operands aligned with the long paths
  logic signed [Z30_W-1:0] zd  [D_Z];
  logic signed [A_W-1:0]   rad [D_RA];
  up_t                     ud  [D_U];
  angle_pair_t             pd  [D_OUT];
  logic signed [A_W-1:0]   ra_q, dec_q;

  always_ff @(posedge clk) begin
    if (en) begin
      zd[0]  <= z30_s1;
      rad[0] <= ra_q;
      ud[0]  <= u_s1;
      pd[0]  <= '{ra: rad[D_RA-1], dec: dec_q};
      for (int k = 1; k < D_Z; k++) zd[k] <= zd[k-1];
      for (int k = 1; k < D_RA; k++) rad[k] <= rad[k-1];
      for (int k = 1; k < D_U; k++) ud[k] <= ud[k-1];
      for (int k = 1; k < D_OUT; k++) pd[k] <= pd[k-1];
    end
  end

  // Right ascension: atan2(py, px) wrapped into [0, 2pi)
  logic signed [ANG30_W-1:0] ra_z, ra_sat, ra_wrap;

  rmrdr_atan2 #(.W(RA_CW), .STEPS(N)) u_ra_atan (
    .clk   (clk),
    .en    (en),
    .y_in  (RA_CW'(py_s1)),
    .x_in  (RA_CW'(px_s1)),
    .z_out (ra_z)
  );

  assign ra_sat  = sat(to_out(ra_z), PI_F);
  assign ra_wrap = (ra_sat < 0) ? ra_sat + TWO_PI_F : ra_sat;

  always_ff @(posedge clk) begin
    if (en) begin
      ra_q <= A_W'(ra_wrap);
    end
  end

  // Declination: atan2(z, sqrt(1 - z^2))
  logic signed [ANG30_W-1:0] dec_z;

  rmrdr_atan2 #(.W(ANG30_W), .STEPS(N)) u_dec_atan (
    .clk   (clk),
    .en    (en),
    .y_in  (ANG30_W'(zd[D_Z-1])),
    .x_in  (ANG30_W'(c30)),
    .z_out (dec_z)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dec_q <= A_W'(sat(to_out(dec_z), HALF_PI_F));
    end
  end

  // Sines and cosines of the quantized angles
  logic signed [XY_W-1:0] cr, sr, cd, sd;

  rmrdr_sincos #(.FRAC_BITS(FRAC_BITS), .STEPS(N), .A_W(A_W)) u_ra_sc (
    .clk     (clk),
    .en      (en),
    .ang     (rad[D_RA-1]),
    .cos_out (cr),
    .sin_out (sr)
  );

  rmrdr_sincos #(.FRAC_BITS(FRAC_BITS), .STEPS(N), .A_W(A_W)) u_dec_sc (
    .clk     (clk),
    .en      (en),
    .ang     (dec_q),
    .cos_out (cd),
    .sin_out (sd)
  );

  // North and east tangent vectors
  logic signed [MP_W-1:0] p_nx, p_ny;
  logic signed [XY_W-1:0] cd_m, cr_m, sr_m;
  logic signed [XY_W-1:0] nx, ny, nz, ex, ey;
  logic signed [MP_W-1:0] nx_rnd, ny_rnd;

  assign nx_rnd = (p_nx + MP_RND) >>> QB;
  assign ny_rnd = (p_ny + MP_RND) >>> QB;

  always_ff @(posedge clk) begin
    if (en) begin
      p_nx <= sd * cr;
      p_ny <= sd * sr;
      cd_m <= cd;
      cr_m <= cr;
      sr_m <= sr;
      nx   <= -nx_rnd[XY_W-1:0];
      ny   <= -ny_rnd[XY_W-1:0];
      nz   <= cd_m;
      ex   <= -sr_m;
      ey   <= cr_m;
    end
  end

  // Dot products of the up column with north and east
  logic signed [PR_W-1:0]  pr_nx, pr_ny, pr_nz, pr_ex, pr_ey;
  logic signed [SUM_W-1:0] north_s, neg_east_s;

  always_ff @(posedge clk) begin
    if (en) begin
      pr_nx      <= ud[D_U-1].x * nx;
      pr_ny      <= ud[D_U-1].y * ny;
      pr_nz      <= ud[D_U-1].z * nz;
      pr_ex      <= ud[D_U-1].x * ex;
      pr_ey      <= ud[D_U-1].y * ey;
      north_s    <= SUM_W'(pr_nx) + SUM_W'(pr_ny) + SUM_W'(pr_nz);
      neg_east_s <= -(SUM_W'(pr_ex) + SUM_W'(pr_ey));
    end
  end

  // Roll: atan2(-(up . east), up . north)
  logic signed [ANG30_W-1:0] roll_z;

  rmrdr_atan2 #(.W(ROLL_CW), .STEPS(N)) u_roll_atan (
    .clk   (clk),
    .en    (en),
    .y_in  (ROLL_CW'(neg_east_s)),
    .x_in  (ROLL_CW'(north_s)),
    .z_out (roll_z)
  );

  // Output register
  logic        [RA_W-1:0]   ra_o;
  logic signed [DEC_W-1:0]  dec_o;
  logic signed [ROLL_W-1:0] roll_o;

  always_ff @(posedge clk) begin
    if (en) begin
      ra_o   <= RA_W'(pd[D_OUT-1].ra);
      dec_o  <= DEC_W'(pd[D_OUT-1].dec);
      roll_o <= ROLL_W'(sat(to_out(roll_z), PI_F));
    end
  end

  assign angles.valid           = vld[LAT-1];
  assign angles.right_ascension = ra_o;
  assign angles.declination     = dec_o;
  assign angles.roll_angle      = roll_o;

  // Checks
  a_ra_range: assert property (@(posedge clk) disable iff (rst)
    angles.valid |-> (angles.right_ascension < TWO_PI_F))
    else $error("right ascension beat at or above two pi");

  a_dec_range: assert property (@(posedge clk) disable iff (rst)
    angles.valid |-> (angles.declination <= HALF_PI_F && angles.declination >= -HALF_PI_F))
    else $error("declination beat outside half pi");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    angles.valid |-> (angles.roll_angle <= PI_F && angles.roll_angle >= -PI_F))
    else $error("roll beat outside pi");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (angles.valid && !angles.ready) |=> $stable(vld))
    else $error("pipeline moved while output beat was held");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the rotation matrix to RA/Dec/roll pipeline.
module tb_top;
  import rmrdr_pkg::*;

  localparam int FRAC = 16;
  localparam int ITERS = 16;
  localparam int LATENCY = 2 * ITERS + 59;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 450;
  localparam longint ONE_IN = 64'sd1 << FRAC;

  typedef struct packed {
    logic [FRAC+2:0]        ra;
    logic signed [FRAC+1:0] dec;
    logic signed [FRAC+2:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [IN_W-1:0] ux, uy, uz, px, py, pz;
  } matrix_t;

  // Fixed-point pointing solution and expected-result store
  class radec_scoreboard;
    angles_t expected_q[$];
    int      mismatches;
    longint  arctan[30] = '{
      843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
      15, 7, 3, 1};
    longint  pi30 = 64'sd3373259426;
    longint  half_pi30 = 64'sd1686629713;
    longint  two_pi30 = 64'sd6746518852;

    function longint q30_to_out(longint v);
      return (v + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    function longint mul30(longint a, longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function longint clip(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function longint root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    // Vectoring CORDIC, Q30 angle out
    function longint vector_angle(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = half_pi30;
        end else begin
          t = x; x = -y; y = t; z = -half_pi30;
        end
      end
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += arctan[i];
        end else begin
          x -= dx; y += dy; z -= arctan[i];
        end
      end
      return z;
    endfunction

    // Rotation CORDIC from an output-scaled angle, Q30 cos/sin out
    function void rotate(longint ang, output longint c, output longint s);
      longint a, x, y, dx, dy;
      bit flip;
      a = ang * (64'sd1 << (30 - FRAC));
      x = 64'sd652032874;
      y = 0;
      flip = 0;
      if (a > pi30) a -= two_pi30;
      if (a > half_pi30) begin
        a -= pi30; flip = 1;
      end else if (a < -half_pi30) begin
        a += pi30; flip = 1;
      end
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (a >= 0) begin
          x -= dx; y += dy; a -= arctan[i];
        end else begin
          x += dx; y -= dy; a += arctan[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function angles_t predict(matrix_t m);
      longint scale, ux, uy, uz, px, py, pz, z30, c30, dec, ra, roll;
      longint cr, sr, cd, sd, nx, ny, north_c, east_c;
      angles_t a;
      scale = 64'sd1 << (30 - FRAC);
      ux = m.ux; uy = m.uy; uz = m.uz;
      px = m.px; py = m.py; pz = m.pz;
      pz = clip(pz, ONE_IN);
      z30 = pz * scale;
      c30 = root_floor((64'd1 << 60) - longint'(z30 * z30));
      dec = clip(q30_to_out(vector_angle(z30, c30)), q30_to_out(half_pi30));
      ra = clip(q30_to_out(vector_angle(py * scale, px * scale)), q30_to_out(pi30));
      if (ra < 0) ra += q30_to_out(two_pi30);
      rotate(ra, cr, sr);
      rotate(dec, cd, sd);
      nx = -mul30(sd, cr);
      ny = -mul30(sd, sr);
      north_c = ux * nx + uy * ny + uz * cd;
      east_c = ux * (-sr) + uy * cr;
      roll = clip(q30_to_out(vector_angle(-east_c, north_c)), q30_to_out(pi30));
      a.ra = ra[FRAC+2:0];
      a.dec = dec[FRAC+1:0];
      a.roll = roll[FRAC+2:0];
      return a;
    endfunction

    function void note_matrix(matrix_t m);
      expected_q.push_back(predict(m));
    endfunction

    function void check_angles(angles_t got);
      angles_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat ra=%0d dec=%0d roll=%0d",
                                       got.ra, got.dec, got.roll);
        return;
      end
      want = expected_q.pop_front();
      if (got.ra !== want.ra || got.dec !== want.dec || got.roll !== want.roll) begin
        mismatches++;
        if (mismatches <= 10)
          $display("angle error: ra %0d/%0d dec %0d/%0d roll %0d/%0d (exp/act)",
                   want.ra, got.ra, want.dec, got.dec, want.roll, got.roll);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bit   calm = 0;
  int   cycles = 0;

  rmrdr_in_if matrix_if ();
  rmrdr_out_if #(.FRAC_BITS(FRAC)) angles_if ();
  radec_scoreboard sb = new();

  rotation_matrix_to_radec_roll #(.FRAC_BITS(FRAC), .CORDIC_STEPS(ITERS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .matrix (matrix_if),
    .angles (angles_if)
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_radec_roll: mismatch");
      $finish;
    end
  end

  // Beat monitors
  always @(posedge clk) begin
    if (!rst && matrix_if.valid && matrix_if.ready)
      sb.note_matrix(matrix_t'{matrix_if.up_x, matrix_if.up_y, matrix_if.up_z,
                               matrix_if.point_x, matrix_if.point_y, matrix_if.point_z});
    if (!rst && angles_if.valid && angles_if.ready)
      sb.check_angles(angles_t'{angles_if.right_ascension, angles_if.declination,
                                angles_if.roll_angle});
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Result sink with random backpressure
  initial begin
    int stall;
    angles_if.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        angles_if.ready = 0;
        repeat (stall) @(negedge clk);
      end
      angles_if.ready = 1;
      do @(posedge clk); while (!angles_if.valid);
      @(negedge clk);
    end
  end

  task automatic send_matrix(matrix_t m);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      matrix_if.valid = 0;
      repeat (gap) @(negedge clk);
    end
    matrix_if.valid = 1;
    matrix_if.up_x = m.ux;
    matrix_if.up_y = m.uy;
    matrix_if.up_z = m.uz;
    matrix_if.point_x = m.px;
    matrix_if.point_y = m.py;
    matrix_if.point_z = m.pz;
    do @(posedge clk); while (!matrix_if.ready);
    @(negedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] near_unit();
    return IN_W'($signed($urandom_range(0, 2 * 65536)) - 65536);
  endfunction

  function automatic logic signed [IN_W-1:0] any_entry();
    return IN_W'($urandom);
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    if ($urandom_range(0, 9) < 7) begin
      // mostly plausible rotation columns with random content
      m = '{near_unit(), near_unit(), near_unit(), near_unit(), near_unit(), near_unit()};
    end else begin
      m = '{any_entry(), any_entry(), any_entry(), any_entry(), any_entry(), any_entry()};
    end
    return m;
  endfunction

  localparam logic signed [IN_W-1:0] MAXV = 18'sh1FFFF;
  localparam logic signed [IN_W-1:0] MINV = 18'sh20000;
  localparam logic signed [IN_W-1:0] P1 = 18'sd65536;
  localparam logic signed [IN_W-1:0] N1 = -18'sd65536;

  initial begin
    matrix_t dir_q[$];
    matrix_if.valid = 0;
    {matrix_if.up_x, matrix_if.up_y, matrix_if.up_z} = '0;
    {matrix_if.point_x, matrix_if.point_y, matrix_if.point_z} = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed corners: zero vectors, axes, clamps, field extremes
    dir_q = '{
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, P1, 18'sd0, 18'sd0, 18'sd0, P1},
      '{18'sd0, P1, 18'sd0, 18'sd0, 18'sd0, N1},
      '{18'sd0, 18'sd0, P1, P1, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, P1, 18'sd0, P1, 18'sd0},
      '{18'sd0, 18'sd0, P1, N1, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, P1, 18'sd0, N1, 18'sd0},
      '{18'sd0, 18'sd0, N1, N1, -18'sd1, 18'sd0},
      '{18'sd0, 18'sd0, N1, N1, 18'sd1, 18'sd0},
      '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV},
      '{MINV, MINV, MINV, MINV, MINV, MINV},
      '{MAXV, MINV, MAXV, MINV, MAXV, MINV},
      '{MINV, MAXV, MINV, MAXV, MINV, MAXV},
      '{P1, 18'sd0, 18'sd0, 18'sd0, 18'sd0, P1 + 18'sd1},
      '{N1, 18'sd0, 18'sd0, 18'sd0, 18'sd0, N1 - 18'sd1},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd46341, 18'sd0, 18'sd46341},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
      '{-18'sd1, -18'sd1, -18'sd1, -18'sd1, -18'sd1, -18'sd1},
      '{18'sd1, 18'sd1, 18'sd1, 18'sd1, 18'sd1, 18'sd1},
      '{18'sd0, N1, 18'sd0, 18'sd40000, -18'sd40000, -18'sd20000}
    };
    foreach (dir_q[i]) send_matrix(dir_q[i]);

    // Hold off until the pipeline has drained
    matrix_if.valid = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    @(negedge clk);

    // Random traffic in groups, some groups with no idling at all
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      send_matrix(random_matrix());
    end
    matrix_if.valid = 0;
    calm = 0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("rotation_matrix_to_radec_roll: match");
    end else begin
      $display("rotation_matrix_to_radec_roll: mismatch");
    end
    $finish;
  end

endmodule

### rotation_matrix_to_radec_roll.f
rtl/core/rmrdr_pkg.sv
rtl/core/rmrdr_in_if.sv
rtl/core/rmrdr_out_if.sv
rtl/core/rmrdr_atan2.sv
rtl/core/rmrdr_sincos.sv
rtl/core/rotation_matrix_to_radec_roll.sv
verif/tb_top.sv
